/* sv/efug_pkg.sv */
// shared constants, types and status codes of the expert first-use grouper
package efug_pkg;

	localparam int NUM_EXPERTS = 256;
	localparam int MAX_TOKENS = 4096;
	localparam int MAX_SLOTS  = 16;
	localparam int MAX_GROUPS = 256;

	localparam int ID_W    = 8;
	localparam int WORD_W  = 32;
	localparam int TOKEN_W = 12;
	localparam int SLOT_W  = 4;
	localparam int GROUP_W = 8;
	localparam int PLACE_W = 12;
	localparam int TOTAL_W = 17;
	localparam int STAT_W  = 3;

	localparam int EXP_AW   = $clog2(NUM_EXPERTS);
	localparam int TOK_CW   = $clog2(MAX_TOKENS + 1);
	localparam int SLOT_CW  = $clog2(MAX_SLOTS + 1);
	localparam int GOPEN_W  = $clog2(MAX_GROUPS + 1);
	localparam int FILL_W   = PLACE_W + 1;
	localparam int PLACE_LIMIT = 1 << PLACE_W;
	localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;

	localparam int IN_DATA_W  = ((ID_W + WORD_W + 7) / 8) * 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_FLD_W  = TOKEN_W + SLOT_W + GROUP_W + PLACE_W + WORD_W + TOTAL_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 1 + STAT_W;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NONFINITE = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FAILED    = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

endpackage

/* sv/efug_ram.sv */
// generic single-write, single-read ram with registered read data
module efug_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/expert_first_use_grouper_top.sv */
// top level of the expert first-use grouper: slot checks, group tables and result register
//
// Takes one router slot per transfer and returns one result per slot, in order. Sustained
// rate is one slot per clock while the result stream is not stalled; a slot is registered
// in the input stage and then in the result stage, which offers its result. The
// per-expert group index and fill count sit in two 256-entry rams with registered reads,
// issued when the slot is taken; a write by the slot just ahead is forwarded, so back-to-back
// slots on the same expert see current values. Group-valid and used-in-token bits are
// flip-flops, so a plan start clears both and a token end clears the used bits at once.
module expert_first_use_grouper_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// expert index, contribution bits
	input  logic [efug_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// plan_start
	input  logic [efug_pkg::IN_USER_W-1:0]   s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// token_number, slot_number, group_number, place_in_group, weight_bits,
	// total_assignments, zero fill
	output logic [efug_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// opened_group, status
	output logic [efug_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	import efug_pkg::*;

	// input stage
	logic                 valid_s1;
	logic [ID_W-1:0]      id_s1;
	logic [WORD_W-1:0]    bits_s1;
	logic                 start_s1;
	logic                 last_s1;

	// result stage
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;
	logic [OUT_USER_W-1:0] user_s2;

	// plan state
	logic [NUM_EXPERTS-1:0] has_q, has_n;
	logic [NUM_EXPERTS-1:0] used_q, used_n;
	logic [GOPEN_W-1:0]    gopen_q, gopen_e;
	logic [TOK_CW-1:0]     tok_q, tok_e;
	logic [SLOT_CW-1:0]    slot_q, slot_e;
	logic [TOTAL_W-1:0]    asg_q, asg_e;
	logic                  failed_q, failed_e;

	// forwarding of the table write that coincided with the read
	logic               fwd_valid_q;
	logic [ID_W-1:0]    fwd_id_q;
	logic [GROUP_W-1:0] fwd_grp_q;
	logic [FILL_W-1:0]  fwd_fill_q;

	logic               in_xfer, adv;
	logic [GROUP_W-1:0] grp_rd, grp_e, grp_val;
	logic [FILL_W-1:0]  fill_rd, fill_e, place_v, fill_next;
	logic               has_e, used_e, fwd_hit, ok, opened;
	status_t            st;
	logic [TOTAL_W-1:0] total_out;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

	efug_ram #(.WIDTH(GROUP_W), .DEPTH(NUM_EXPERTS)) u_group_ram (
		.clk   (clk),
		.we    (adv && ok),
		.waddr (id_s1[EXP_AW-1:0]),
		.wdata (grp_val),
		.re    (in_xfer),
		.raddr (s_axis_tdata[EXP_AW-1:0]),
		.rdata (grp_rd)
	);

	efug_ram #(.WIDTH(FILL_W), .DEPTH(NUM_EXPERTS)) u_fill_ram (
		.clk   (clk),
		.we    (adv && ok),
		.waddr (id_s1[EXP_AW-1:0]),
		.wdata (fill_next),
		.re    (in_xfer),
		.raddr (s_axis_tdata[EXP_AW-1:0]),
		.rdata (fill_rd)
	);

	always_comb begin
		has_e    = !start_s1 && has_q[id_s1[EXP_AW-1:0]];
		used_e   = !start_s1 && used_q[id_s1[EXP_AW-1:0]];
		gopen_e  = start_s1 ? '0 : gopen_q;
		tok_e    = start_s1 ? '0 : tok_q;
		slot_e   = start_s1 ? '0 : slot_q;
		asg_e    = start_s1 ? '0 : asg_q;
		failed_e = !start_s1 && failed_q;

		fwd_hit = fwd_valid_q && (fwd_id_q == id_s1);
		grp_e   = fwd_hit ? fwd_grp_q : grp_rd;
		fill_e  = fwd_hit ? fwd_fill_q : fill_rd;
		place_v = has_e ? fill_e : '0;
		grp_val = has_e ? grp_e : gopen_e[GROUP_W-1:0];
		fill_next = place_v + FILL_W'(1);
		opened  = !has_e;

		if (failed_e) begin
			st = ST_FAILED;
		end else if (tok_e >= TOK_CW'(MAX_TOKENS) || slot_e >= SLOT_CW'(MAX_SLOTS) ||
			     int'(id_s1) >= NUM_EXPERTS) begin
			st = ST_OVERFLOW;
		end else if (bits_s1[30:23] == 8'hFF) begin
			st = ST_NONFINITE;
		end else if (used_e) begin
			st = ST_DUPLICATE;
		end else if (place_v >= FILL_W'(PLACE_LIMIT) || asg_e >= TOTAL_W'(TOTAL_MAX) ||
			     (!has_e && gopen_e >= GOPEN_W'(MAX_GROUPS))) begin
			st = ST_OVERFLOW;
		end else begin
			st = ST_OK;
		end
		ok = (st == ST_OK);

		has_n  = start_s1 ? '0 : has_q;
		used_n = start_s1 ? '0 : used_q;
		if (ok) begin
			has_n[id_s1[EXP_AW-1:0]] = 1'b1;
			if (last_s1) begin
				used_n = '0;
			end else begin
				used_n[id_s1[EXP_AW-1:0]] = 1'b1;
			end
		end

		total_out = ok ? asg_e + TOTAL_W'(1) : asg_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			has_q       <= '0;
			used_q      <= '0;
			gopen_q     <= '0;
			tok_q       <= '0;
			slot_q      <= '0;
			asg_q       <= '0;
			failed_q    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1    <= 1'b1;
				fwd_valid_q <= adv && ok;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				has_q    <= has_n;
				used_q   <= used_n;
				asg_q    <= total_out;
				failed_q <= failed_e || (st != ST_OK && st != ST_FAILED);
				if (ok) begin
					gopen_q <= opened ? gopen_e + GOPEN_W'(1) : gopen_e;
					tok_q   <= last_s1 ? tok_e + TOK_CW'(1) : tok_e;
					slot_q  <= last_s1 ? '0 : slot_e + SLOT_CW'(1);
				end else begin
					gopen_q <= gopen_e;
					tok_q   <= tok_e;
					slot_q  <= slot_e;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			id_s1      <= s_axis_tdata[ID_W-1:0];
			bits_s1    <= s_axis_tdata[ID_W+WORD_W-1:ID_W];
			start_s1   <= s_axis_tuser[0];
			last_s1    <= s_axis_tlast;
			fwd_id_q   <= id_s1;
			fwd_grp_q  <= grp_val;
			fwd_fill_q <= fill_next;
		end
		if (adv) begin
			data_s2 <= {
				(OUT_DATA_W - OUT_FLD_W)'(0),
				total_out,
				bits_s1,
				ok ? place_v[PLACE_W-1:0] : PLACE_W'(0),
				ok ? grp_val : GROUP_W'(0),
				slot_e[SLOT_W-1:0],
				tok_e[TOKEN_W-1:0]
			};
			user_s2 <= {st, ok && opened};
		end
	end

endmodule

/* sv/efug_checker.sv */
// port-level checks on the expert first-use grouper result stream, bound to the top level
module efug_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [efug_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [efug_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	import efug_pkg::*;

	logic [STAT_W-1:0]  st;
	logic [GROUP_W-1:0] grp;
	logic [PLACE_W-1:0] place;
	logic [TOTAL_W-1:0] total;

	assign st    = m_axis_tuser[STAT_W:1];
	assign grp   = m_axis_tdata[TOKEN_W+SLOT_W+GROUP_W-1:TOKEN_W+SLOT_W];
	assign place = m_axis_tdata[TOKEN_W+SLOT_W+GROUP_W+PLACE_W-1:TOKEN_W+SLOT_W+GROUP_W];
	assign total = m_axis_tdata[OUT_FLD_W-1:OUT_FLD_W-TOTAL_W];

	// stalled transfer stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// rejected slot carries no group
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != ST_OK |-> grp == '0 && place == '0 && !m_axis_tuser[0])
		else $error("rejected slot reports a group");

	// a new group starts at place zero and only on an accepted slot
	a_open_place: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> place == '0 && st == ST_OK)
		else $error("opened group with nonzero place");

	// an accepted slot is counted
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_OK |-> total != '0)
		else $error("accepted slot with zero assignment count");

endmodule

bind expert_first_use_grouper_top efug_checker u_efug_checker (.*);
